[rtl/srt_pkg.sv]
// shared types and constants for the sorted range table
package srt_pkg;

   localparam int KEY_BITS      = 64;
   localparam int TAG_PORT_BITS = 32;
   localparam int DATA_BITS     = 2 * KEY_BITS + TAG_PORT_BITS;

   typedef enum logic [1:0] {
      REQ_INSERT   = 2'd0,
      REQ_CONTAINS = 2'd1,
      REQ_NEXT     = 2'd2,
      REQ_EXTENTS  = 2'd3
   } req_kind_type;

   // per-cell strobes from the top level
   typedef struct packed {
      logic capture;
      logic insert;
   } cell_ctl_type;

   // per-cell selection flags, valid while an item sits in the compare stage
   typedef struct packed {
      logic last;
      logic first;
      logic eq;
      logic inr;
   } pick_flags_type;

endpackage

[rtl/srt_cell.sv]
// one table slot: holds a range, compares against the key, shifts toward its neighbor
module srt_cell import srt_pkg::*; #(
   parameter int TAG_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic [KEY_BITS-1:0] key,
   input  logic [KEY_BITS-1:0] new_start,
   input  logic [KEY_BITS-1:0] new_length,
   input  logic [TAG_BITS-1:0] new_tag,
   input  logic [KEY_BITS-1:0] prev_start,
   input  logic [KEY_BITS-1:0] prev_length,
   input  logic [TAG_BITS-1:0] prev_tag,
   input  logic                prev_valid,
   input  logic                prev_le,
   input  logic                next_valid,
   input  logic                next_le,
   output logic [KEY_BITS-1:0] start,
   output logic [KEY_BITS-1:0] length,
   output logic [TAG_BITS-1:0] tag,
   output logic                valid,
   output logic                le,
   output pick_flags_type      picks,
   output logic [KEY_BITS-1:0] end_pick
);

   logic [KEY_BITS-1:0] start_ff;
   logic [KEY_BITS-1:0] length_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic                valid_ff;
   logic                le_ff;
   logic                eq_ff;
   logic                inr_ff;
   logic [KEY_BITS-1:0] end_sum;
   logic                shift_in;

   assign end_sum  = start_ff + length_ff;
   assign shift_in = ctl.insert && !le_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         le_ff    <= 1'b0;
      end else begin
         if (ctl.capture) begin
            le_ff <= valid_ff && (start_ff <= key);
         end
         if (shift_in) begin
            valid_ff <= prev_le ? 1'b1 : prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         eq_ff  <= (start_ff == key);
         inr_ff <= (key < end_sum);
      end
      if (shift_in) begin
         // the first slot past the insertion point takes the new range
         if (prev_le) begin
            start_ff  <= new_start;
            length_ff <= new_length;
            tag_ff    <= new_tag;
         end else begin
            start_ff  <= prev_start;
            length_ff <= prev_length;
            tag_ff    <= prev_tag;
         end
      end
   end

   assign start  = start_ff;
   assign length = length_ff;
   assign tag    = tag_ff;
   assign valid  = valid_ff;
   assign le     = le_ff;

   assign picks.last  = le_ff && !next_le;
   assign picks.first = !le_ff && prev_le && valid_ff;
   assign picks.eq    = eq_ff;
   assign picks.inr   = inr_ff;

   assign end_pick = (valid_ff && !next_valid) ? end_sum : '0;

endmodule

[rtl/sorted_range_table.sv]
// sorted range table: a row of slots kept in start order, with insert and lookups
//
//  channel   dir  handshake              payload
//  req_      in   req_tvalid/req_tready  tuser: req_type; tdata: key, range_length, tag
//  rsp_      out  rsp_tvalid/rsp_tready  tuser: hit, table_full; tdata: start, length, tag
//
// on the accept edge all slots compare their start against the key; when the item
// advances, the selected slot is muxed into the output register and, for an
// insert, the slots past the insertion point shift. a waiting result holds the
// compare stage until rsp_tready; reset clears the slot valid bits and the
// handshake state, the range contents are not cleared.
module sorted_range_table import srt_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int TAG_BITS      = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,  // req_type
   input  logic [DATA_BITS-1:0] req_tdata,  // key, range_length, tag
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [1:0]           rsp_tuser,  // hit, table_full
   output logic [DATA_BITS-1:0] rsp_tdata   // out_start, out_length, out_tag
);

   localparam int N = TABLE_ENTRIES;

   // neighbor links, slot i sits at index i+1
   logic [KEY_BITS-1:0] start_chain  [N+2];
   logic [KEY_BITS-1:0] length_chain [N+2];
   logic [TAG_BITS-1:0] tag_chain    [N+2];
   logic [N+1:0]        valid_chain;
   logic [N+1:0]        le_chain;
   pick_flags_type      picks        [N];
   logic [KEY_BITS-1:0] end_picks    [N];
   logic [N-1:0]        valid_vec;
   logic [N-1:0]        le_vec;

   logic [KEY_BITS-1:0]          req_key;
   logic [KEY_BITS-1:0]          req_length;
   logic [TAG_PORT_BITS-1:0]     req_tag;
   logic [TAG_BITS+TAG_PORT_BITS-1:0] tag_wide;

   logic                s1_valid_ff;
   req_kind_type        s1_type_ff;
   logic [KEY_BITS-1:0] s1_key_ff;
   logic [KEY_BITS-1:0] s1_length_ff;
   logic [TAG_BITS-1:0] s1_tag_ff;
   logic [KEY_BITS-1:0] s1_end_ff;

   logic                 rsp_valid_ff;
   logic                 hit_ff;
   logic                 full_ff;
   logic [KEY_BITS-1:0]  out_start_ff;
   logic [KEY_BITS-1:0]  out_length_ff;
   logic [TAG_PORT_BITS-1:0] out_tag_ff;

   logic                capture;
   logic                advance;
   logic                table_is_full;
   cell_ctl_type        ctl;

   logic                last_any;
   logic                last_eq;
   logic                last_inr;
   logic [KEY_BITS-1:0] last_start;
   logic [KEY_BITS-1:0] last_length;
   logic [TAG_BITS-1:0] last_tag;
   logic                first_any;
   logic [KEY_BITS-1:0] first_start;
   logic [KEY_BITS-1:0] first_length;
   logic [TAG_BITS-1:0] first_tag;
   logic [KEY_BITS-1:0] end_sel;

   logic                      hit_in;
   logic                      full_in;
   logic [KEY_BITS-1:0]       out_start_in;
   logic [KEY_BITS-1:0]       out_length_in;
   logic [TAG_BITS-1:0]       out_tag_in;
   logic [TAG_BITS+TAG_PORT_BITS-1:0] out_tag_wide;

   assign req_key    = req_tdata[KEY_BITS-1:0];
   assign req_length = req_tdata[2*KEY_BITS-1:KEY_BITS];
   assign req_tag    = req_tdata[DATA_BITS-1:2*KEY_BITS];
   assign tag_wide   = {{TAG_BITS{1'b0}}, req_tag};

   assign req_tready    = !s1_valid_ff;
   assign capture       = req_tvalid && req_tready;
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign table_is_full = valid_vec[N-1];

   assign ctl.capture = capture;
   assign ctl.insert  = advance && (s1_type_ff == REQ_INSERT) && !table_is_full;

   assign start_chain[0]    = '0;
   assign length_chain[0]   = '0;
   assign tag_chain[0]      = '0;
   assign start_chain[N+1]  = '0;
   assign length_chain[N+1] = '0;
   assign tag_chain[N+1]    = '0;
   assign valid_chain[0]    = 1'b0;
   assign valid_chain[N+1]  = 1'b0;
   assign le_chain[0]       = 1'b1;
   assign le_chain[N+1]     = 1'b0;
   assign valid_vec         = valid_chain[N:1];
   assign le_vec            = le_chain[N:1];

   for (genvar i = 0; i < N; i++) begin : g_cell
      srt_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .key         (req_key),
         .new_start   (s1_key_ff),
         .new_length  (s1_length_ff),
         .new_tag     (s1_tag_ff),
         .prev_start  (start_chain[i]),
         .prev_length (length_chain[i]),
         .prev_tag    (tag_chain[i]),
         .prev_valid  (valid_chain[i]),
         .prev_le     (le_chain[i]),
         .next_valid  (valid_chain[i+2]),
         .next_le     (le_chain[i+2]),
         .start       (start_chain[i+1]),
         .length      (length_chain[i+1]),
         .tag         (tag_chain[i+1]),
         .valid       (valid_chain[i+1]),
         .le          (le_chain[i+1]),
         .picks       (picks[i]),
         .end_pick    (end_picks[i])
      );
   end

   // one-hot and-or selection across the slots
   always_comb begin
      last_any     = 1'b0;
      last_eq      = 1'b0;
      last_inr     = 1'b0;
      last_start   = '0;
      last_length  = '0;
      last_tag     = '0;
      first_any    = 1'b0;
      first_start  = '0;
      first_length = '0;
      first_tag    = '0;
      end_sel      = '0;
      for (int i = 0; i < N; i++) begin
         last_any     = last_any | picks[i].last;
         last_eq      = last_eq | (picks[i].last & picks[i].eq);
         last_inr     = last_inr | (picks[i].last & picks[i].inr);
         last_start   = last_start | ({KEY_BITS{picks[i].last}} & start_chain[i+1]);
         last_length  = last_length | ({KEY_BITS{picks[i].last}} & length_chain[i+1]);
         last_tag     = last_tag | ({TAG_BITS{picks[i].last}} & tag_chain[i+1]);
         first_any    = first_any | picks[i].first;
         first_start  = first_start | ({KEY_BITS{picks[i].first}} & start_chain[i+1]);
         first_length = first_length | ({KEY_BITS{picks[i].first}} & length_chain[i+1]);
         first_tag    = first_tag | ({TAG_BITS{picks[i].first}} & tag_chain[i+1]);
         end_sel      = end_sel | end_picks[i];
      end
   end

   always_comb begin
      hit_in        = 1'b0;
      full_in       = 1'b0;
      out_start_in  = '0;
      out_length_in = '0;
      out_tag_in    = '0;
      unique case (s1_type_ff)
         REQ_INSERT: begin
            full_in = table_is_full;
         end
         REQ_CONTAINS: begin
            if (last_inr) begin
               hit_in        = 1'b1;
               out_start_in  = last_start;
               out_length_in = last_length;
               out_tag_in    = last_tag;
            end
         end
         REQ_NEXT: begin
            priority if (last_eq) begin
               hit_in        = 1'b1;
               out_start_in  = last_start;
               out_length_in = last_length;
               out_tag_in    = last_tag;
            end else if (first_any) begin
               hit_in        = 1'b1;
               out_start_in  = first_start;
               out_length_in = first_length;
               out_tag_in    = first_tag;
            end else begin
               hit_in        = 1'b0;
            end
         end
         REQ_EXTENTS: begin
            if (valid_vec[0]) begin
               hit_in        = 1'b1;
               out_start_in  = start_chain[1];
               out_length_in = s1_end_ff - start_chain[1];
            end
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   assign out_tag_wide = {{TAG_PORT_BITS{1'b0}}, out_tag_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (capture) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         s1_type_ff   <= req_kind_type'(req_tuser);
         s1_key_ff    <= req_key;
         s1_length_ff <= req_length;
         s1_tag_ff    <= tag_wide[TAG_BITS-1:0];
         // end of the last range, taken while the table is stable
         s1_end_ff    <= end_sel;
      end
      if (advance) begin
         hit_ff        <= hit_in;
         full_ff       <= full_in;
         out_start_ff  <= out_start_in;
         out_length_ff <= out_length_in;
         out_tag_ff    <= out_tag_wide[TAG_PORT_BITS-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {full_ff, hit_ff};
   assign rsp_tdata  = {out_tag_ff, out_length_ff, out_start_ff};

   // occupied slots always form a prefix of the row
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + (N+1)'(1)))
      else $error("occupied slots are not contiguous");

   // slots at or below the key form a prefix while an item is in the compare stage
   a_le_prefix: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot({1'b0, le_vec} + (N+1)'(1)))
      else $error("compare flags are not a prefix");

   // a committed insert adds exactly one slot
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("insert did not add one entry");

   // a dropped insert never reports a hit
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && full_ff) |-> !hit_ff)
      else $error("dropped insert reported a hit");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the sorted range table: directed and random requests, checked in order
module tb;
   import srt_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [63:0] ALL_ONES = '1;

   typedef struct {
      logic        hit;
      logic [63:0] start;
      logic [63:0] length;
      logic [31:0] tag;
      logic        full;
   } lookup_result_type;

   // mirror of the range table plus the queue of results still owed by the block
   class range_table_checker;
      logic [63:0]       starts[DEPTH];
      logic [63:0]       lengths[DEPTH];
      logic [31:0]       tags[DEPTH];
      int                used = 0;
      int                mismatches = 0;
      lookup_result_type pending_results[$];

      function lookup_result_type found(int idx);
         lookup_result_type res;
         res.hit    = 1'b1;
         res.start  = starts[idx];
         res.length = lengths[idx];
         res.tag    = tags[idx];
         res.full   = 1'b0;
         return res;
      endfunction

      function void note_request(req_kind_type kind, logic [63:0] key,
                                 logic [63:0] len, logic [31:0] tag);
         lookup_result_type res;
         int                below;
         logic [63:0]       stop;
         res = '{hit: 1'b0, start: '0, length: '0, tag: '0, full: 1'b0};
         // entries are sorted, so this is one past the last start at or below the key
         below = 0;
         for (int i = 0; i < used; i++)
            if (starts[i] <= key) below = i + 1;
         case (kind)
            REQ_INSERT: begin
               if (used >= DEPTH) begin
                  res.full = 1'b1;
               end else begin
                  for (int i = used; i > below; i--) begin
                     starts[i]  = starts[i-1];
                     lengths[i] = lengths[i-1];
                     tags[i]    = tags[i-1];
                  end
                  starts[below]  = key;
                  lengths[below] = len;
                  tags[below]    = tag;
                  used++;
               end
            end
            REQ_CONTAINS: begin
               if (below > 0) begin
                  // end wraps at 64 bits, so a wrapping range never hits
                  stop = starts[below-1] + lengths[below-1];
                  if (key < stop) res = found(below - 1);
               end
            end
            REQ_NEXT: begin
               if (below > 0 && starts[below-1] == key) res = found(below - 1);
               else if (below < used) res = found(below);
            end
            REQ_EXTENTS: begin
               if (used > 0) begin
                  res.hit    = 1'b1;
                  res.start  = starts[0];
                  res.length = starts[used-1] + lengths[used-1] - starts[0];
               end
            end
         endcase
         pending_results.push_back(res);
      endfunction

      function void check_field(string field, logic [63:0] want_v, logic [63:0] got_v);
         if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_response(logic [1:0] user, logic [DATA_BITS-1:0] data);
         lookup_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual user %b data %h",
                     $time, user, data);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         check_field("hit", 64'(want.hit), 64'(user[0]));
         check_field("table_full", 64'(want.full), 64'(user[1]));
         check_field("out_start", want.start, data[63:0]);
         check_field("out_length", want.length, data[127:64]);
         check_field("out_tag", 64'(want.tag), 64'(data[159:128]));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [1:0]           req_tuser = '0;  // req_type
   logic [DATA_BITS-1:0] req_tdata = '0;  // key, range_length, tag
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [1:0]           rsp_tuser;       // hit, table_full
   logic [DATA_BITS-1:0] rsp_tdata;       // out_start, out_length, out_tag

   range_table_checker sb = new;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int phase = 0;
   int cycle_count = 0;

   sorted_range_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_kind_type'(req_tuser), req_tdata[63:0], req_tdata[127:64],
                         req_tdata[159:128]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata);
   end

   // receiver: random stalls, plus one long hold-off once idling stops
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (phase == 2 && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_item(req_kind_type kind, logic [63:0] key, logic [63:0] len,
                            logic [31:0] tag);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {tag, len, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // lookup keys cluster around entry starts and ends so hits and edges are common
   function automatic logic [63:0] lookup_key();
      int          idx;
      logic [63:0] base;
      if (sb.used == 0 || $urandom_range(0, 4) == 0) return {$urandom, $urandom};
      idx  = $urandom_range(0, sb.used - 1);
      base = $urandom_range(0, 1) ? sb.starts[idx] : sb.starts[idx] + sb.lengths[idx];
      return base + 64'($urandom_range(0, 4)) - 64'd2;
   endfunction

   task automatic random_item();
      req_kind_type kind;
      logic [63:0]  key;
      logic [63:0]  len;
      kind = req_kind_type'($urandom_range(0, 3));
      if (kind == REQ_INSERT) begin
         case ($urandom_range(0, 4))
            0: begin
               key = {$urandom, $urandom};
               len = {$urandom, $urandom};
            end
            1: begin
               // duplicate start goes after the existing ones
               key = (sb.used > 0) ? sb.starts[$urandom_range(0, sb.used - 1)]
                                   : 64'($urandom_range(0, 2000));
               len = 64'($urandom_range(0, 300));
            end
            default: begin
               key = 64'($urandom_range(0, 2000));
               len = 64'($urandom_range(0, 300));
            end
         endcase
      end else begin
         key = lookup_key();
         len = {$urandom, $urandom};
      end
      send_item(kind, key, len, $urandom);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table
      send_item(REQ_EXTENTS, 64'd0, 64'd0, 32'd0);
      send_item(REQ_CONTAINS, 64'd5, ALL_ONES, 32'hFFFF_FFFF);
      send_item(REQ_NEXT, 64'd0, 64'd0, 32'd0);
      // equal starts, later one wins the containing lookup
      send_item(REQ_INSERT, 64'd100, 64'd50, 32'hAAAA_5555);
      send_item(REQ_INSERT, 64'd100, 64'd10, 32'h0000_0001);
      send_item(REQ_CONTAINS, 64'd105, 64'd0, 32'd0);
      send_item(REQ_CONTAINS, 64'd120, 64'd0, 32'd0);
      send_item(REQ_NEXT, 64'd100, 64'd0, 32'd0);
      send_item(REQ_NEXT, 64'd99, 64'd0, 32'd0);
      send_item(REQ_NEXT, 64'd101, 64'd0, 32'd0);
      // zero length never contains
      send_item(REQ_INSERT, 64'd0, 64'd0, 32'd0);
      send_item(REQ_CONTAINS, 64'd0, 64'd0, 32'd0);
      // range whose end wraps past zero
      send_item(REQ_INSERT, ALL_ONES - 64'd5, 64'd10, 32'hFFFF_FFFF);
      send_item(REQ_CONTAINS, ALL_ONES - 64'd2, 64'd0, 32'd0);
      send_item(REQ_EXTENTS, 64'd0, 64'd0, 32'd0);
      send_item(REQ_INSERT, ALL_ONES, ALL_ONES, 32'h8000_0000);
      send_item(REQ_NEXT, ALL_ONES, 64'd0, 32'd0);
      send_item(REQ_CONTAINS, ALL_ONES, 64'd0, 32'd0);
      send_item(REQ_EXTENTS, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               tx_idle_pct = 8;
               rx_idle_pct = 78;
            end
            1: begin
               tx_idle_pct = 78;
               rx_idle_pct = 8;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         phase = p;
         for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item();
      end
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/srt_pkg.sv
rtl/srt_cell.sv
rtl/sorted_range_table.sv
test/tb.sv
